// File: rtl/core/nfcfe_pkg.sv
// Package for the NFC host frame encoder.
// Holds the frame constants, header byte positions and the memory control struct.
// No dependencies.
`timescale 1ns / 1ps

package nfcfe_pkg;

  // Default total frame capacity; the payload buffer holds eight fewer bytes.
  localparam int DEF_MAX_FRAME_BYTES = 64;
  localparam int FRAME_OVERHEAD      = 8;

  // Fixed frame bytes.
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'hFF;
  localparam logic [7:0] BYTE_TFI   = 8'hD4;

  // Positions of the header bytes at the front of a frame.
  localparam int HDR_PRE0   = 0;
  localparam int HDR_PRE1   = 1;
  localparam int HDR_START  = 2;
  localparam int HDR_LEN    = 3;
  localparam int HDR_LCS    = 4;
  localparam int HDR_TFI    = 5;
  localparam int HDR_BYTES  = 6;

  // Enables from the sequencer to the payload memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: rtl/core/nfc_host_frame_encoder.sv
// Top level of the NFC host frame encoder: sequencer plus payload buffer.
// Depends on nfcfe_pkg, nfcfe_store and nfcfe_seq.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_cmd_byte[7:0], in_last_byte
//   out_     output     out_valid/out_stall  out_frame_byte[7:0], out_frame_last,
//                                             out_too_long
//
// A command byte is taken whenever in_valid is high while the block collects. After the
// last byte the frame plays out, its payload read from the payload memory read port:
// count + 8 bytes, or one byte for a dropped command. The bytes follow one per cycle
// while the output does not stall, and the input stalls until the final byte leaves the
// read stage. Output stalls hold the output register and the read stage in place.
// Reset is synchronous and active low; the buffer needs no clearing pass.
`timescale 1ns / 1ps

module nfc_host_frame_encoder
  import nfcfe_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_cmd_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last,
  output logic       out_too_long
);

  localparam int CAP = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Command collection and frame playout.
  nfcfe_seq #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .AW              (AW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd_byte    (in_cmd_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .out_too_long   (out_too_long),
    .mem_ctl        (mem_ctl),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  // Payload buffer.
  nfcfe_store #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/core/nfcfe_store.sv
// Payload buffer of the NFC host frame encoder: one write port, one read port.
// Read data is registered. Depends on nfcfe_pkg.
`timescale 1ns / 1ps

module nfcfe_store
  import nfcfe_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_FRAME_BYTES - FRAME_OVERHEAD,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      mem_ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/nfcfe_seq.sv
// Sequencer of the NFC host frame encoder: collects the command into the
// payload buffer, then plays out the frame through a read stage and an output
// register. Depends on nfcfe_pkg.
`timescale 1ns / 1ps

module nfcfe_seq
  import nfcfe_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int AW = ((MAX_FRAME_BYTES - FRAME_OVERHEAD) > 1) ?
                     $clog2(MAX_FRAME_BYTES - FRAME_OVERHEAD) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_cmd_byte,
  input  logic          in_last_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_frame_byte,
  output logic          out_frame_last,
  output logic          out_too_long,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);

  localparam int CAP = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int CW  = $clog2(CAP + 1);
  localparam int IW  = $clog2(MAX_FRAME_BYTES);

  localparam logic MODE_COLLECT = 1'b0;
  localparam logic MODE_EMIT    = 1'b1;

  logic          mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          ovf_r, ovf_nxt;
  logic          err_r, err_nxt;
  logic [IW-1:0] iss_idx_r, iss_idx_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic [IW-1:0] s1_idx_r, s1_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_tl_r, out_tl_nxt;

  logic          in_acc;
  logic          full;
  logic          store_en;
  logic          adv;
  logic          issue;
  logic [IW-1:0] last_idx;
  logic          s1_last;
  logic [7:0]    len;
  logic [7:0]    lcs;
  logic [7:0]    dcs;
  logic [7:0]    byte_sel;
  logic          last_sel;

  // Handshake and buffer status.
  assign in_stall = (mode_r != MODE_COLLECT);
  assign in_acc   = in_valid && (mode_r == MODE_COLLECT);
  assign full     = (count_r == CW'(CAP));
  assign store_en = in_acc && !ovf_r && !full;
  assign adv      = !out_valid_r || !out_stall;
  assign issue    = (mode_r == MODE_EMIT) && adv && !iss_done_r;
  assign last_idx = err_r ? '0 : (IW'(count_r) + IW'(FRAME_OVERHEAD - 1));
  assign s1_last  = (s1_idx_r == last_idx);

  // Memory accesses: writes while collecting, reads while emitting.
  assign mem_ctl.wr_en = store_en;
  assign mem_ctl.rd_en = issue;
  assign wr_addr       = AW'(count_r);
  assign wr_data       = in_cmd_byte;
  assign rd_addr       = AW'(iss_idx_r - IW'(HDR_BYTES));

  // Length and checksum bytes.
  assign len = 8'(count_r) + 8'd1;
  assign lcs = 8'd0 - len;
  assign dcs = 8'd0 - (BYTE_TFI + sum_r);

  // Frame byte for the index held in the read stage.
  always_comb begin
    byte_sel = BYTE_ZERO;
    last_sel = 1'b0;
    if (err_r) begin
      last_sel = 1'b1;
    end else if (s1_last) begin
      last_sel = 1'b1;
    end else if (s1_idx_r == last_idx - IW'(1)) begin
      byte_sel = dcs;
    end else if (s1_idx_r >= IW'(HDR_BYTES)) begin
      byte_sel = rd_data;
    end else begin
      case (s1_idx_r)
        IW'(HDR_PRE0):  byte_sel = BYTE_ZERO;
        IW'(HDR_PRE1):  byte_sel = BYTE_ZERO;
        IW'(HDR_START): byte_sel = BYTE_START;
        IW'(HDR_LEN):   byte_sel = len;
        IW'(HDR_LCS):   byte_sel = lcs;
        IW'(HDR_TFI):   byte_sel = BYTE_TFI;
        default:        byte_sel = BYTE_ZERO;
      endcase
    end
  end

  // Next-state logic for collection, issue, read stage and output register.
  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    err_nxt       = err_r;
    iss_idx_nxt   = iss_idx_r;
    iss_done_nxt  = iss_done_r;
    s1_valid_nxt  = s1_valid_r;
    s1_idx_nxt    = s1_idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_tl_nxt    = out_tl_r;

    case (mode_r)
      MODE_COLLECT: begin
        if (in_acc) begin
          if (store_en) begin
            count_nxt = count_r + CW'(1);
            sum_nxt   = sum_r + in_cmd_byte;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_byte) begin
            mode_nxt     = MODE_EMIT;
            err_nxt      = ovf_r || full;
            iss_idx_nxt  = '0;
            iss_done_nxt = 1'b0;
          end
        end
      end
      MODE_EMIT: begin
        if (adv) begin
          if (!iss_done_r) begin
            s1_valid_nxt = 1'b1;
            s1_idx_nxt   = iss_idx_r;
            if (iss_idx_r == last_idx) begin
              iss_done_nxt = 1'b1;
            end else begin
              iss_idx_nxt = iss_idx_r + IW'(1);
            end
          end else begin
            s1_valid_nxt = 1'b0;
          end
          // The final byte leaves the read stage: the command is finished.
          if (s1_valid_r && s1_last) begin
            mode_nxt  = MODE_COLLECT;
            count_nxt = '0;
            sum_nxt   = 8'd0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        mode_nxt = MODE_COLLECT;
      end
    endcase

    // The output register takes the read stage whenever it is free.
    if (adv) begin
      out_valid_nxt = s1_valid_r;
      out_byte_nxt  = byte_sel;
      out_last_nxt  = last_sel;
      out_tl_nxt    = err_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_COLLECT;
      count_r     <= '0;
      sum_r       <= 8'd0;
      ovf_r       <= 1'b0;
      iss_done_r  <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      iss_done_r  <= iss_done_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    iss_idx_r  <= iss_idx_nxt;
    s1_idx_r   <= s1_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_tl_r   <= out_tl_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;
  assign out_too_long   = out_tl_r;

endmodule

// File: rtl/core/nfcfe_checker.sv
// Port-level checks for the NFC host frame encoder, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module nfcfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_cmd_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_last,
  input logic       out_too_long
);

  // A stalled result request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_frame_last) && $stable(out_too_long))
    else $error("stalled result changed");

  // A dropped command shows as a single zero byte that ends the result.
  a_too_long_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_long |-> out_frame_last && (out_frame_byte == 8'h00))
    else $error("malformed too_long result");

  // Taking the last byte of a command starts playout, which stalls the input.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> in_stall)
    else $error("input not stalled after last byte");

  // While a frame is mid-flight on the output, no new request is taken.
  a_mid_frame_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> in_stall)
    else $error("input accepted during frame playout");

endmodule

bind nfc_host_frame_encoder nfcfe_checker u_nfcfe_checker (.*);
